@@ src/ppf_pkg.sv @@
`default_nettype none
package ppf_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_PROJECT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // status codes of a result word
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_TAKEN    = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_DIRECT   = 3'd3;
  localparam logic [2:0] ST_FILLED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  // configuration register indexes
  localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
  localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] CFG_CENTER_X = 3'd2;
  localparam logic [2:0] CFG_CENTER_Y = 3'd3;
  localparam logic [2:0] CFG_WIDTH    = 3'd4;
  localparam logic [2:0] CFG_HEIGHT   = 3'd5;
  localparam logic [2:0] CFG_WINDOW   = 3'd6;

  localparam int DIV_STEPS = 64;

  typedef enum logic [1:0] {ASRC_CLR, ASRC_PROJ, ASRC_READ, ASRC_WIN} addr_src_t;
  typedef enum logic [1:0] {DSRC_PROJ, DSRC_R, DSRC_G, DSRC_B} div_src_t;
  typedef enum logic [1:0] {RGB_ZERO, RGB_MEM, RGB_KEEP} rgb_src_t;

  typedef enum logic [4:0] {
    S_INIT_CLR, S_IDLE, S_CLR, S_Z_CHK, S_DIVY_GO, S_DIVY_WAIT, S_MUL_X,
    S_DIVX_GO, S_DIVX_WAIT, S_PROJ_CHK, S_PROJ_WR, S_RD_CHK, S_RD_DATA,
    S_WIN_ISSUE, S_WIN_ACC, S_MEAN_CHK, S_MR_WAIT, S_MG_GO, S_MG_WAIT,
    S_MB_GO, S_MB_WAIT, S_RESULT
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       clr_step;
    logic       mul_en;
    logic       mul_sel_x;
    logic       div_start;
    div_src_t   div_src;
    logic       coord_row_ld;
    logic       coord_col_ld;
    addr_src_t  addr_src;
    logic       mem_we;
    logic       win_init;
    logic       win_acc;
    logic       mean_ld;
    logic       set_res;
    logic [2:0] res_code;
    rgb_src_t   res_rgb;
    logic       load_out;
  } ppf_cmd_t;

  typedef struct packed {
    logic z_bad;
    logic div_done;
    logic div_busy;
    logic row_ok;
    logic col_ok;
    logic in_frame;
    logic mem_mark;
    logic border_ok;
    logic win_last;
    logic win_empty;
    logic clr_last;
    logic out_free;
  } ppf_stat_t;

endpackage
`default_nettype wire

@@ src/ppf_if.sv @@
`default_nettype none
interface ppf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [7:0]         in_red;
  logic [7:0]         in_green;
  logic [7:0]         in_blue;
  logic [7:0]         read_row;
  logic [7:0]         read_col;

  modport source (output valid, cmd, pos_x, pos_y, pos_z, in_red, in_green, in_blue,
                  read_row, read_col, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, in_red, in_green, in_blue,
                read_row, read_col, output ready);
endinterface

interface ppf_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, status, out_red, out_green, out_blue, input ready);
  modport sink (input valid, status, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

@@ src/ppf_div.sv @@
`default_nettype none
module ppf_div import ppf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);

  logic [31:0] rem;
  logic [31:0] den;
  logic [6:0]  cnt;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quotient[63]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[31:0] : shifted[31:0];
      quotient <= {quotient[62:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ src/ppf_ctrl.sv @@
`default_nettype none
module ppf_ctrl import ppf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] in_cmd,
  output logic      in_ready,
  input  ppf_stat_t st,
  output ppf_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT_CLR: if (st.clr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_PROJECT: state_next = S_Z_CHK;
            CMD_READ:    state_next = S_RD_CHK;
            CMD_CLEAR:   state_next = S_CLR;
            default:     state_next = S_RESULT;
          endcase
        end
      end
      S_CLR:       if (st.clr_last) state_next = S_RESULT;
      S_Z_CHK:     state_next = st.z_bad ? S_RESULT : S_DIVY_GO;
      S_DIVY_GO:   state_next = S_DIVY_WAIT;
      S_DIVY_WAIT: if (st.div_done) state_next = S_MUL_X;
      S_MUL_X:     state_next = S_DIVX_GO;
      S_DIVX_GO:   state_next = S_DIVX_WAIT;
      S_DIVX_WAIT: if (st.div_done) state_next = S_PROJ_CHK;
      S_PROJ_CHK:  state_next = (st.row_ok && st.col_ok) ? S_PROJ_WR : S_RESULT;
      S_PROJ_WR:   state_next = S_RESULT;
      S_RD_CHK:    state_next = st.in_frame ? S_RD_DATA : S_RESULT;
      S_RD_DATA:   state_next = (!st.mem_mark && st.border_ok) ? S_WIN_ISSUE : S_RESULT;
      S_WIN_ISSUE: state_next = S_WIN_ACC;
      S_WIN_ACC:   state_next = st.win_last ? S_MEAN_CHK : S_WIN_ISSUE;
      S_MEAN_CHK:  state_next = st.win_empty ? S_RESULT : S_MR_WAIT;
      S_MR_WAIT:   if (st.div_done) state_next = S_MG_GO;
      S_MG_GO:     state_next = S_MG_WAIT;
      S_MG_WAIT:   if (st.div_done) state_next = S_MB_GO;
      S_MB_GO:     state_next = S_MB_WAIT;
      S_MB_WAIT:   if (st.div_done) state_next = S_RESULT;
      S_RESULT:    if (st.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_src  = DSRC_PROJ;
    cmd.addr_src = ASRC_PROJ;
    cmd.res_rgb  = RGB_ZERO;
    cmd.res_code = ST_EMPTY;
    in_ready = 1'b0;
    case (state)
      S_INIT_CLR: begin
        cmd.addr_src = ASRC_CLR;
        cmd.mem_we   = 1'b1;
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid && in_cmd != CMD_PROJECT && in_cmd != CMD_READ &&
            in_cmd != CMD_CLEAR) begin
          cmd.set_res = 1'b1;
        end
      end
      S_CLR: begin
        cmd.addr_src = ASRC_CLR;
        cmd.mem_we   = 1'b1;
        cmd.clr_step = 1'b1;
        cmd.res_code = ST_CLEARED;
        cmd.set_res  = st.clr_last;
      end
      S_Z_CHK: begin
        cmd.mul_en   = 1'b1;
        cmd.res_code = ST_REJECTED;
        cmd.set_res  = st.z_bad;
      end
      S_DIVY_GO:   cmd.div_start = 1'b1;
      S_DIVY_WAIT: cmd.coord_row_ld = st.div_done;
      S_MUL_X: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_x = 1'b1;
      end
      S_DIVX_GO:   cmd.div_start = 1'b1;
      S_DIVX_WAIT: cmd.coord_col_ld = st.div_done;
      S_PROJ_CHK: begin
        cmd.res_code = ST_REJECTED;
        cmd.set_res  = !(st.row_ok && st.col_ok);
      end
      S_PROJ_WR: begin
        cmd.set_res  = 1'b1;
        cmd.mem_we   = !st.mem_mark;
        cmd.res_code = st.mem_mark ? ST_TAKEN : ST_STORED;
      end
      S_RD_CHK: begin
        cmd.addr_src = ASRC_READ;
        cmd.set_res  = !st.in_frame;
      end
      S_RD_DATA: begin
        cmd.addr_src = ASRC_READ;
        if (st.mem_mark) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_DIRECT;
          cmd.res_rgb  = RGB_MEM;
        end else if (!st.border_ok) begin
          cmd.set_res = 1'b1;
        end else begin
          cmd.win_init = 1'b1;
        end
      end
      S_WIN_ISSUE: cmd.addr_src = ASRC_WIN;
      S_WIN_ACC: begin
        cmd.addr_src = ASRC_WIN;
        cmd.win_acc  = 1'b1;
      end
      S_MEAN_CHK: begin
        cmd.set_res   = st.win_empty;
        cmd.div_start = !st.win_empty;
        cmd.div_src   = DSRC_R;
      end
      S_MR_WAIT: begin
        cmd.div_src = DSRC_R;
        cmd.mean_ld = st.div_done;
      end
      S_MG_GO: begin
        cmd.div_src   = DSRC_G;
        cmd.div_start = 1'b1;
      end
      S_MG_WAIT: begin
        cmd.div_src = DSRC_G;
        cmd.mean_ld = st.div_done;
      end
      S_MB_GO: begin
        cmd.div_src   = DSRC_B;
        cmd.div_start = 1'b1;
      end
      S_MB_WAIT: begin
        cmd.div_src  = DSRC_B;
        cmd.mean_ld  = st.div_done;
        cmd.set_res  = st.div_done;
        cmd.res_code = ST_FILLED;
        cmd.res_rgb  = RGB_KEEP;
      end
      S_RESULT: cmd.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ src/ppf_dp.sv @@
`default_nettype none
module ppf_dp import ppf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  read_row,
  input  logic [7:0]  read_col,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  ppf_cmd_t    cmd,
  output ppf_stat_t   st
);

  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = RW + CW;
  localparam int HCAP = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int WCAP = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;

  // configuration
  logic [23:0] focal_x, focal_y, center_x, center_y;
  logic [8:0]  frame_width, frame_height;
  logic [3:0]  window_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= '0;
      focal_y      <= '0;
      center_x     <= '0;
      center_y     <= '0;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      window_size  <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:  focal_x      <= cfg_data;
        CFG_FOCAL_Y:  focal_y      <= cfg_data;
        CFG_CENTER_X: center_x     <= cfg_data;
        CFG_CENTER_Y: center_y     <= cfg_data;
        CFG_WIDTH:    frame_width  <= cfg_data[8:0];
        CFG_HEIGHT:   frame_height <= cfg_data[8:0];
        CFG_WINDOW:   window_size  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [8:0] eff_w, eff_h;
  logic [2:0] half;
  assign eff_w = (frame_width > 9'(WCAP)) ? 9'(WCAP) : frame_width;
  assign eff_h = (frame_height > 9'(HCAP)) ? 9'(HCAP) : frame_height;
  assign half  = window_size[3:1];

  // captured word
  logic signed [31:0] px, py, pz;
  logic [23:0] rgb_in;
  logic [7:0]  rrow, rcol;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px     <= pos_x;
      py     <= pos_y;
      pz     <= pos_z;
      rgb_in <= {in_red, in_green, in_blue};
      rrow   <= read_row;
      rcol   <= read_col;
    end
  end

  // |p| * focal, sign kept apart
  logic [31:0] p_sel, p_mag;
  logic [23:0] f_sel;
  logic [55:0] prod;
  logic        neg;

  assign p_sel = cmd.mul_sel_x ? px : py;
  assign f_sel = cmd.mul_sel_x ? focal_x : focal_y;
  assign p_mag = p_sel[31] ? (~p_sel + 32'd1) : p_sel;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= p_mag * f_sel;
      neg  <= p_sel[31];
    end
  end

  // shared divider
  logic [15:0] sum_r, sum_g, sum_b, sum_sel;
  logic [7:0]  npix;
  logic [63:0] div_a, quo;
  logic [31:0] div_b;
  logic        div_busy, div_done;

  always_comb begin
    case (cmd.div_src)
      DSRC_R:  sum_sel = sum_r;
      DSRC_G:  sum_sel = sum_g;
      default: sum_sel = sum_b;
    endcase
    if (cmd.div_src == DSRC_PROJ) begin
      div_a = {prod, 8'd0};
      div_b = pz;
    end else begin
      div_a = 64'({sum_sel, 1'b0}) + 64'(npix);
      div_b = 32'({npix, 1'b0});
    end
  end

  ppf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // quotient to pixel coordinate: saturate, add center, round
  logic [48:0]        q_sat;
  logic signed [50:0] q_sgn, v, v_rnd;
  logic [23:0]        c_sel;
  logic [8:0]         lim;
  logic [34:0]        r_pos;
  logic [8:0]         coord;
  logic               coord_ok;

  always_comb begin
    c_sel = cmd.coord_row_ld ? center_y : center_x;
    lim   = cmd.coord_row_ld ? eff_h : eff_w;
    q_sat = (quo > 64'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : quo[48:0];
    q_sgn = neg ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    v     = q_sgn + $signed({19'd0, c_sel, 8'd0});
    v_rnd = v + 51'sd32768;
    r_pos = v_rnd[50:16];
    if (v < 0) begin
      coord    = '0;
      coord_ok = (v > -51'sd32768) && (lim != 9'd0);
    end else begin
      coord    = r_pos[8:0];
      coord_ok = r_pos < {26'd0, lim};
    end
  end

  logic [8:0] row_val, col_val;
  logic       row_ok, col_ok;

  always_ff @(posedge clk) begin
    if (cmd.coord_row_ld) begin
      row_val <= coord;
      row_ok  <= coord_ok;
    end
    if (cmd.coord_col_ld) begin
      col_val <= coord;
      col_ok  <= coord_ok;
    end
  end

  // window walk
  logic [3:0] wa, wb, hpos, hneg;
  logic [8:0] wrow, wcol;
  logic       w_center;

  assign hpos     = {1'b0, half};
  assign hneg     = 4'd0 - hpos;
  assign wrow     = {1'b0, rrow} + {{5{wa[3]}}, wa};
  assign wcol     = {1'b0, rcol} + {{5{wb[3]}}, wb};
  assign w_center = (wa == 4'd0) && (wb == 4'd0);

  // pixel store: mark bit over color
  logic [24:0]   mem [2**AW];
  logic [24:0]   rdata;
  logic [AW-1:0] addr, clr_cnt;
  logic [24:0]   wdata;

  always_comb begin
    case (cmd.addr_src)
      ASRC_CLR:  addr = clr_cnt;
      ASRC_PROJ: addr = {RW'(row_val), CW'(col_val)};
      ASRC_READ: addr = {RW'(rrow), CW'(rcol)};
      default:   addr = {RW'(wrow), CW'(wcol)};
    endcase
    wdata = (cmd.addr_src == ASRC_CLR) ? 25'd0 : {1'b1, rgb_in};
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      wa    <= hneg;
      wb    <= hneg;
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      npix  <= '0;
    end else if (cmd.win_acc) begin
      if (rdata[24] && !w_center) begin
        sum_r <= sum_r + 16'(rdata[23:16]);
        sum_g <= sum_g + 16'(rdata[15:8]);
        sum_b <= sum_b + 16'(rdata[7:0]);
        npix  <= npix + 8'd1;
      end
      if (wb == hpos) begin
        wb <= hneg;
        wa <= wa + 4'd1;
      end else begin
        wb <= wb + 4'd1;
      end
    end
  end

  // pending result and output register
  logic [2:0]  res_status;
  logic [23:0] res_rgb;

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      case (cmd.res_rgb)
        RGB_ZERO: res_rgb <= '0;
        RGB_MEM:  res_rgb <= rdata[23:0];
        default: ;
      endcase
    end
    if (cmd.mean_ld) begin
      case (cmd.div_src)
        DSRC_R:  res_rgb[23:16] <= quo[7:0];
        DSRC_G:  res_rgb[15:8]  <= quo[7:0];
        default: res_rgb[7:0]   <= quo[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status    <= res_status;
      out_red   <= res_rgb[23:16];
      out_green <= res_rgb[15:8];
      out_blue  <= res_rgb[7:0];
    end
  end

  always_comb begin
    st.z_bad     = pz[31] || (pz == 32'sd0);
    st.div_done  = div_done;
    st.div_busy  = div_busy;
    st.row_ok    = row_ok;
    st.col_ok    = col_ok;
    st.in_frame  = ({1'b0, rrow} < eff_h) && ({1'b0, rcol} < eff_w);
    st.mem_mark  = rdata[24];
    st.border_ok = ({2'b0, rrow} >= {7'd0, half}) &&
                   ({2'b0, rrow} + {7'd0, half} < {1'b0, eff_h}) &&
                   ({2'b0, rcol} >= {7'd0, half}) &&
                   ({2'b0, rcol} + {7'd0, half} < {1'b0, eff_w});
    st.win_last  = (wa == hpos) && (wb == hpos);
    st.win_empty = (npix == 8'd0);
    st.clr_last  = &clr_cnt;
    st.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ src/point_projection_hole_fill_top.sv @@
// Pinhole point projection with hole fill.
// in_ch carries one command word: project a colored point (Q16.16 x/y/z),
// read a pixel, or clear the frame. out_ch returns exactly one result word
// per command: a status code and, for a read, the pixel color.
// Configuration (focal lengths, principal point, frame size, fill window) is
// written through cfg_we/cfg_index/cfg_data while the block is idle.
// Work per word, from accept to result ready:
//   project: two 64-step divisions by depth in a shared radix-2 divider
//            dominate; a rejected depth goes straight to the result.
//   read:    a marked or out-of-range pixel is answered directly; a hole fill
//            walks the window one entry at a time, (2*half+1)^2 entries, then
//            three 64-step divisions for the channel means.
//   clear:   one store entry per cycle, 2^(clog2(H)+clog2(W)) entries
//            (65536 with the default parameters).
// One word is in work at a time; in_ch is ready only in the idle state.
// Reset runs the same clearing pass over the mark store before the first
// word is taken; configuration writes are taken during it.
// A finished result sits in an output register; the next word is accepted
// while it waits, and a stalled receiver only holds off the next result.
`default_nettype none
module point_projection_hole_fill_top import ppf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  ppf_in_if.sink      in_ch,
  ppf_out_if.source   out_ch
);

  ppf_cmd_t  cmd;
  ppf_stat_t st;

  // sequencer: one state per step of a command
  ppf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // multiplier, divider, pixel store, window accumulators, output register
  ppf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_x     (in_ch.pos_x),
    .pos_y     (in_ch.pos_y),
    .pos_z     (in_ch.pos_z),
    .in_red    (in_ch.in_red),
    .in_green  (in_ch.in_green),
    .in_blue   (in_ch.in_blue),
    .read_row  (in_ch.read_row),
    .read_col  (in_ch.read_col),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (out_ch.status),
    .out_red   (out_ch.out_red),
    .out_green (out_ch.out_green),
    .out_blue  (out_ch.out_blue),
    .cmd       (cmd),
    .st        (st)
  );

  // a result is loaded only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free) else $error("result loaded over pending word");

  // idle means no store write and no division launched
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!cmd.mem_we && !cmd.div_start)) else $error("work while idle");

  // the divider is never restarted mid-operation
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !st.div_busy) else $error("divider restarted while busy");

  // the clearing pass holds off input right after reset
  a_init_clear: assert property (@(posedge clk)
    $fell(rst) |-> !in_ch.ready) else $error("input taken before clearing pass");

endmodule
`default_nettype wire

@@ verif/point_projection_hole_fill_top_tb.sv @@
`default_nettype none
module point_projection_hole_fill_top_tb;
  import ppf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int NPIX = MAXW * MAXH;
  localparam longint QSAT = 64'sd1 <<< 48;
  // worst case: 3 clears of 65536 store entries plus ~1400 words
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] x, y, z;
    logic [7:0]         r, g, b;
    logic [7:0]         row, col;
  } word_t;

  typedef struct {
    logic [2:0] status;
    logic [7:0] r, g, b;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_FOCAL_X;
  logic [23:0] cfg_data = '0;

  ppf_in_if  in_ch ();
  ppf_out_if out_ch ();

  point_projection_hole_fill_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: mirror of the registers and of the mark/color stores
  // ---------------------------------------------------------------------------
  logic [23:0] m_fx, m_fy, m_cx, m_cy;
  logic [8:0]  m_w, m_h;
  logic [3:0]  m_win;
  bit          marked [NPIX];
  logic [23:0] color [NPIX];

  word_t   pending_words [$];
  result_t expected_results [$];
  int      errors = 0;
  int      accepted_words = 0;
  int      results_seen = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      cycles = 0;

  // round(center + p*focal/z) in the block's fixed point
  function automatic longint project_axis(longint p, longint z, logic [23:0] f, logic [23:0] c);
    longint t, q, v;
    t = p * (longint'(f) <<< 8);
    q = t / z;
    if (q > QSAT) q = QSAT;
    if (q < -QSAT) q = -QSAT;
    v = q + (longint'(c) <<< 8);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  // applies one word to the mirrored stores and returns its result
  function automatic result_t apply_word(word_t w);
    result_t o;
    longint fw, fh, row, col, hf;
    int sr, sg, sb, n, idx, k;
    o = '{ST_EMPTY, 8'd0, 8'd0, 8'd0};
    fw = (m_w > MAXW) ? MAXW : m_w;
    fh = (m_h > MAXH) ? MAXH : m_h;
    case (w.cmd)
      CMD_PROJECT: begin
        o.status = ST_REJECTED;
        if (w.z > 0) begin
          row = project_axis(longint'(w.y), longint'(w.z), m_fy, m_cy);
          col = project_axis(longint'(w.x), longint'(w.z), m_fx, m_cx);
          if (row >= 0 && row < fh && col >= 0 && col < fw) begin
            idx = int'(row) * MAXW + int'(col);
            if (marked[idx]) o.status = ST_TAKEN;
            else begin
              marked[idx] = 1'b1;
              color[idx] = {w.r, w.g, w.b};
              o.status = ST_STORED;
            end
          end
        end
      end
      CMD_READ: begin
        row = w.row;
        col = w.col;
        hf = m_win / 2;
        idx = int'(row) * MAXW + int'(col);
        if (row >= fh || col >= fw) o.status = ST_EMPTY;
        else if (marked[idx]) begin
          o.status = ST_DIRECT;
          {o.r, o.g, o.b} = color[idx];
        end else if (row >= hf && row < fh - hf && col >= hf && col < fw - hf) begin
          sr = 0; sg = 0; sb = 0; n = 0;
          for (longint a = -hf; a <= hf; a++)
            for (longint bb = -hf; bb <= hf; bb++) begin
              k = int'((row + a) * MAXW + col + bb);
              if ((a != 0 || bb != 0) && marked[k]) begin
                sr += color[k][23:16];
                sg += color[k][15:8];
                sb += color[k][7:0];
                n++;
              end
            end
          if (n > 0) begin
            o.status = ST_FILLED;
            o.r = 8'((2 * sr + n) / (2 * n));
            o.g = 8'((2 * sg + n) / (2 * n));
            o.b = 8'((2 * sb + n) / (2 * n));
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NPIX; i++) marked[i] = 1'b0;
        o.status = ST_CLEARED;
      end
      default: o.status = ST_EMPTY;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: idles per phase of the run; prediction happens at acceptance
  // ---------------------------------------------------------------------------
  word_t cur_word;
  bit    send_gap;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_READ;
      {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} <= '0;
      {in_ch.in_red, in_ch.in_green, in_ch.in_blue} <= '0;
      {in_ch.read_row, in_ch.read_col} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_word(cur_word));
        accepted_words++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        // sender idles 9% in the first third, 47% in the second, never after
        send_gap = (accepted_words < 470) ? ($urandom_range(0, 99) < 9) :
                   (accepted_words < 940) ? ($urandom_range(0, 99) < 47) : 1'b0;
        if (pending_words.size() > 0 && !send_gap) begin
          cur_word = pending_words.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= cur_word.cmd;
          in_ch.pos_x <= cur_word.x;
          in_ch.pos_y <= cur_word.y;
          in_ch.pos_z <= cur_word.z;
          in_ch.in_red <= cur_word.r;
          in_ch.in_green <= cur_word.g;
          in_ch.in_blue <= cur_word.b;
          in_ch.read_row <= cur_word.row;
          in_ch.read_col <= cur_word.col;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted in its own process: the block fills up
  // (one word in work, one in the output register) and drops in_ch.ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (!hold_done && results_seen == 30) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest expectation
  // ---------------------------------------------------------------------------
  result_t want;
  bit      recv_stall;

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result word, status %0d", out_ch.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
          if (out_ch.out_red !== want.r) report_mismatch("red", out_ch.out_red, want.r);
          if (out_ch.out_green !== want.g) report_mismatch("green", out_ch.out_green, want.g);
          if (out_ch.out_blue !== want.b) report_mismatch("blue", out_ch.out_blue, want.b);
        end
        results_seen++;
      end
      recv_stall = (accepted_words < 470) ? ($urandom_range(0, 99) < 47) :
                   (accepted_words < 940) ? ($urandom_range(0, 99) < 9) : 1'b0;
      out_ch.ready <= !(hold_left > 0 || recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_config(logic [23:0] fx, fy, cx, cy, logic [8:0] w, h, logic [3:0] win);
    logic [23:0] vals [7];
    vals = '{fx, fy, cx, cy, 24'(w), 24'(h), 24'(win)};
    for (int i = 0; i < 7; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    m_fx = fx; m_fy = fy; m_cx = cx; m_cy = cy; m_w = w; m_h = h; m_win = win;
  endtask

  // sender pauses until every expected result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic word_t mk_read(int row, int col);
    word_t w;
    w = '{CMD_READ, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
          8'(row), 8'(col)};
    return w;
  endfunction

  function automatic word_t mk_point(longint x, longint y, longint z);
    word_t w;
    w = '{CMD_PROJECT, 32'(x), 32'(y), 32'(z), 8'($urandom), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom)};
    return w;
  endfunction

  // inverse projection: coordinate that lands near the given pixel
  function automatic longint aim(int pix, longint z, logic [23:0] f, logic [23:0] c);
    longint v;
    if (f == 0) return longint'($signed($urandom));
    v = ((longint'(pix) <<< 8) - longint'(c)) * z / longint'(f) +
        longint'(int'($urandom_range(0, 2))) - 1;
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v;
  endfunction

  task automatic random_phase(int n, int read_pct, int noise_pct);
    int fw, fh, sel;
    longint z;
    word_t w;
    fw = (m_w > MAXW) ? MAXW : m_w;
    fh = (m_h > MAXH) ? MAXH : m_h;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < noise_pct) begin
        // noise: full-range fields, unused command code now and then
        w = mk_point($signed($urandom), $signed($urandom), $signed($urandom));
        w.row = 8'($urandom);
        w.col = 8'($urandom);
        case ($urandom_range(0, 3))
          0: w.cmd = CMD_READ;
          1: w.cmd = 2'd3;
          default: w.cmd = CMD_PROJECT;
        endcase
      end else if (sel < noise_pct + read_pct) begin
        w = mk_read($urandom_range(0, (fh > 0) ? fh - 1 : 0) + $urandom_range(0, 1),
                    $urandom_range(0, (fw > 0) ? fw - 1 : 0) + $urandom_range(0, 1));
      end else begin
        z = $urandom_range(32'h0000_4000, 32'h0004_0000);
        w = mk_point(aim($urandom_range(0, (fw > 0) ? fw : 1), z, m_fx, m_cx),
                     aim($urandom_range(0, (fh > 0) ? fh : 1), z, m_fy, m_cy), z);
      end
      pending_words.push_back(w);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    m_fx = 0; m_fy = 0; m_cx = 0; m_cy = 0; m_w = 256; m_h = 256; m_win = 3;
    for (int i = 0; i < NPIX; i++) begin
      marked[i] = 1'b0;
      color[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: 128 px focal, principal point at the frame center
    write_config(24'd128 << 8, 24'd128 << 8, 24'd128 << 8, 24'd128 << 8, 9'd256, 9'd256, 4'd3);
    pending_words.push_back(mk_point(0, 0, 0));                         // zero depth
    pending_words.push_back(mk_point(0, 0, -1));                        // negative depth
    pending_words.push_back(mk_point(0, 0, -64'sh8000_0000));
    pending_words.push_back(mk_point(64'sh7FFF_FFFF, -64'sh8000_0000, 1));  // saturates
    pending_words.push_back(mk_point(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
    pending_words.push_back(mk_point(-64'sh0001_0000, -64'sh0001_0000, 64'sh0001_0000)); // (0,0)
    pending_words.push_back(mk_point(64'sh0000_FF00, 64'sh0000_FF00, 64'sh0001_0000));
    begin
      word_t w;
      w = mk_point(0, 0, 64'sh0001_0000);                              // pixel (128,128)
      {w.r, w.g, w.b} = 24'hFFFFFF;
      pending_words.push_back(w);
      w = mk_point(0, 0, 64'sh0001_0000);                              // already taken
      pending_words.push_back(w);
      w = mk_point(64'sh0000_0200, 0, 64'sh0001_0000);                 // pixel (128,129)
      {w.r, w.g, w.b} = 24'h000000;
      pending_words.push_back(w);
    end
    pending_words.push_back(mk_read(128, 128));                         // direct
    pending_words.push_back(mk_read(127, 129));                         // filled
    pending_words.push_back(mk_read(0, 0));                             // marked corner
    pending_words.push_back(mk_read(255, 255));                         // border, empty
    pending_words.push_back(mk_read(200, 10));                          // no neighbors
    begin
      word_t w;
      w = mk_read(1, 1);
      w.cmd = 2'd3;                                                     // unused command
      pending_words.push_back(w);
      w.cmd = CMD_CLEAR;
      pending_words.push_back(w);
    end
    pending_words.push_back(mk_read(128, 128));                         // gone after clear
    drain();

    // random phases across several settings
    random_phase(300, 30, 10);
    write_config(24'd16 << 8, 24'd16 << 8, 24'd16 << 8, 24'd16 << 8, 9'd32, 9'd32, 4'd5);
    random_phase(350, 40, 8);
    // extremes: width saturates, zero height empties the frame
    write_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9'd511, 9'd0, 4'd15);
    random_phase(120, 40, 20);
    write_config(24'd0, 24'd0, 24'd0, 24'd0, 9'd1, 9'd1, 4'd0);
    random_phase(60, 40, 10);
    begin
      word_t w;
      w = mk_read(0, 0);
      w.cmd = CMD_CLEAR;
      pending_words.push_back(w);
    end
    drain();
    write_config(24'd40 << 8, 24'd30 << 8, 24'd32 << 8, 24'd24 << 8, 9'd64, 9'd48, 4'd15);
    random_phase(150, 30, 8);
    write_config(24'($urandom_range(1 << 10, 1 << 16)), 24'($urandom_range(1 << 10, 1 << 16)),
                 24'($urandom), 24'($urandom), 9'($urandom_range(1, 256)),
                 9'($urandom_range(1, 256)), 4'($urandom));
    random_phase(150, 35, 10);
    write_config(24'd100 << 8, 24'd100 << 8, 24'd8 << 8, 24'd8 << 8, 9'd20, 9'd20, 4'd3);
    random_phase(300, 40, 8);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/ppf_pkg.sv
src/ppf_if.sv
src/ppf_div.sv
src/ppf_ctrl.sv
src/ppf_dp.sv
src/point_projection_hole_fill_top.sv
verif/point_projection_hole_fill_top_tb.sv
